// ===== rtl/qnc_pkg.sv =====
package qnc_pkg;

  localparam int unsigned CompW   = 16;
  localparam int unsigned SumW    = 33;
  localparam int unsigned AccW    = 64;
  localparam int unsigned QBits   = 15;
  localparam int unsigned Lanes   = 4;

  localparam logic [SumW-1:0] SumMinOk  = 33'd16777216;
  localparam logic [SumW-1:0] SumMaxOk  = 33'd150994944;
  localparam logic [SumW-1:0] SumWarnLo = 33'd42949672;
  localparam logic [SumW-1:0] SumWarnHi = 33'd96636765;
  localparam logic [QBits-1:0] UnitQ14  = 15'd16384;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WARN  = 2'd1,
    ST_ZERO  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ORD_WXYZ = 1'b0,
    ORD_XYZW = 1'b1
  } order_t;

endpackage

// ===== rtl/quaternion_normalize_check.sv =====
// Channel   Ports                                   Direction
// in        in_valid in_stall in_comp_a..in_comp_d  word in, stall out
// out       out_valid out_stall out_norm_x..w,      word out, stall in
//           out_status
// cfg       cfg_valid cfg_ready cfg_data            order bit in, always ready
//
// One word per cycle while out is not stalled. Stages: input, square, sum, 15 search
// steps (one result bit per step, per lane) and the output register.
// Reset (synchronous, rst_n low) clears valid bits and the order bit.
// A stall on out while the output register is full freezes every stage together
// and raises in_stall, so nothing is dropped or repeated.
module quaternion_normalize_check import qnc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CompW-1:0] in_comp_a,
  input  logic signed [CompW-1:0] in_comp_b,
  input  logic signed [CompW-1:0] in_comp_c,
  input  logic signed [CompW-1:0] in_comp_d,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [CompW-1:0] out_norm_x,
  output logic signed [CompW-1:0] out_norm_y,
  output logic signed [CompW-1:0] out_norm_z,
  output logic signed [CompW-1:0] out_norm_w,
  output logic [1:0]              out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data
);

  localparam int unsigned NStg = QBits + 1;

  logic adv;
  order_t order_r;

  // stage A: reordered components x,y,z,w
  logic                    va_r;
  logic signed [CompW-1:0] qa_r [Lanes];
  // stage B: squares
  logic                    vb_r;
  logic [2*CompW-2:0]      sq_r [Lanes];
  logic                    sgnb_r [Lanes];
  // search pipeline, index 0 is the setup after the sum
  logic                    vs_r   [NStg];
  status_t                 st_r   [NStg];
  logic [SumW-1:0]         s_r    [NStg];
  logic [AccW-1:0]         rhs_r  [NStg][Lanes];
  logic [AccW-1:0]         p_r    [NStg][Lanes];
  logic [AccW-1:0]         qv_r   [NStg][Lanes];
  logic [QBits-1:0]        c_r    [NStg][Lanes];
  logic                    sg_r   [NStg][Lanes];
  // output
  logic                    vo_r;
  logic signed [CompW-1:0] no_r [Lanes];
  status_t                 so_r;

  assign adv       = !vo_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORD_WXYZ;
    end else if (cfg_valid) begin
      order_r <= order_t'(cfg_data);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k < NStg; k++) vs_r[k] <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vs_r[0] <= vb_r;
      for (int k = 1; k < NStg; k++) vs_r[k] <= vs_r[k-1];
      vo_r <= vs_r[NStg-1];
    end
  end

  // reorder and square
  always_ff @(posedge clk) begin
    if (adv) begin
      if (order_r == ORD_WXYZ) begin
        qa_r[0] <= in_comp_b; qa_r[1] <= in_comp_c;
        qa_r[2] <= in_comp_d; qa_r[3] <= in_comp_a;
      end else begin
        qa_r[0] <= in_comp_a; qa_r[1] <= in_comp_b;
        qa_r[2] <= in_comp_c; qa_r[3] <= in_comp_d;
      end
      for (int l = 0; l < Lanes; l++) begin
        sq_r[l]   <= (2*CompW-1)'($signed(qa_r[l]) * $signed(qa_r[l]));
        sgnb_r[l] <= qa_r[l][CompW-1];
      end
    end
  end

  // sum of squares, thresholds, search setup
  logic [SumW-1:0] sum_nxt;
  status_t         st_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int l = 0; l < Lanes; l++) sum_nxt = sum_nxt + SumW'(sq_r[l]);
    if (sum_nxt == '0) begin
      st_nxt = ST_ZERO;
    end else if (sum_nxt < SumMinOk || sum_nxt > SumMaxOk) begin
      st_nxt = ST_RANGE;
    end else if (sum_nxt <= SumWarnLo || sum_nxt >= SumWarnHi) begin
      st_nxt = ST_WARN;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0]  <= sum_nxt;
      st_r[0] <= st_nxt;
      for (int l = 0; l < Lanes; l++) begin
        rhs_r[0][l] <= AccW'(sq_r[l]) << 30;
        p_r[0][l]   <= AccW'(sum_nxt);          // t = -1: t^2*S
        qv_r[0][l]  <= -AccW'(sum_nxt);         // t*S
        c_r[0][l]   <= '0;
        sg_r[0][l]  <= sgnb_r[l];
      end
    end
  end

  // Greedy bit search for the largest c with (2c-1)^2*S <= mag^2*2^30.
  // Setting bit b moves t by 2^(b+1), so t^2*S and t*S update by shifts.
  for (genvar k = 0; k < QBits; k++) begin : g_srch
    localparam int unsigned B = QBits - 1 - k;
    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [QBits-1:0] cand_nxt;
      logic [AccW-1:0]  pc_nxt;
      logic             take_nxt;

      always_comb begin
        cand_nxt = c_r[k][l] | (QBits'(1) << B);
        pc_nxt   = p_r[k][l] + (qv_r[k][l] << (B + 2))
                   + (AccW'(s_r[k]) << (2*B + 2));
        take_nxt = (cand_nxt <= UnitQ14) && (pc_nxt <= rhs_r[k][l]);
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rhs_r[k+1][l] <= rhs_r[k][l];
          sg_r[k+1][l]  <= sg_r[k][l];
          if (take_nxt) begin
            c_r[k+1][l]  <= cand_nxt;
            p_r[k+1][l]  <= pc_nxt;
            qv_r[k+1][l] <= qv_r[k][l] + (AccW'(s_r[k]) << (B + 1));
          end else begin
            c_r[k+1][l]  <= c_r[k][l];
            p_r[k+1][l]  <= p_r[k][l];
            qv_r[k+1][l] <= qv_r[k][l];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_r[k+1]  <= s_r[k];
        st_r[k+1] <= st_r[k];
      end
    end
  end

  // sign restore and rejection mask
  always_ff @(posedge clk) begin
    if (adv) begin
      so_r <= st_r[NStg-1];
      for (int l = 0; l < Lanes; l++) begin
        if (st_r[NStg-1] == ST_ZERO || st_r[NStg-1] == ST_RANGE) begin
          no_r[l] <= '0;
        end else if (sg_r[NStg-1][l]) begin
          no_r[l] <= -$signed(CompW'(c_r[NStg-1][l]));
        end else begin
          no_r[l] <= $signed(CompW'(c_r[NStg-1][l]));
        end
      end
    end
  end

  assign out_valid  = vo_r;
  assign out_norm_x = no_r[0];
  assign out_norm_y = no_r[1];
  assign out_norm_z = no_r[2];
  assign out_norm_w = no_r[3];
  assign out_status = so_r;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import qnc_pkg::*;

  // one quaternion word on the input side
  typedef struct packed {
    logic signed [CompW-1:0] a;
    logic signed [CompW-1:0] b;
    logic signed [CompW-1:0] c;
    logic signed [CompW-1:0] d;
  } quat_word_t;

  // one normalized result word
  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
    logic signed [CompW-1:0] w;
    status_t                 st;
  } unit_word_t;

  localparam int PipeDepth = 19;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CompW-1:0] in_comp_a, in_comp_b, in_comp_c, in_comp_d;
  logic out_valid;
  logic out_stall;
  logic signed [CompW-1:0] out_norm_x, out_norm_y, out_norm_z, out_norm_w;
  logic [1:0] out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  quaternion_normalize_check uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_comp_a  (in_comp_a),
    .in_comp_b  (in_comp_b),
    .in_comp_c  (in_comp_c),
    .in_comp_d  (in_comp_d),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_norm_x (out_norm_x),
    .out_norm_y (out_norm_y),
    .out_norm_z (out_norm_z),
    .out_norm_w (out_norm_w),
    .out_status (out_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  quat_word_t pending_quats[$];   // words waiting for the driver
  unit_word_t expected_units[$];  // predicted results, oldest first
  int         mismatch_count = 0;
  order_t     cur_order = ORD_WXYZ;  // predictor's copy of the order bit

  // Scale one component by 2^14 / sqrt(s), nearest with ties away from zero.
  // Binary search for the largest q with (2q-1)^2 * s <= raw^2 * 2^30.
  function automatic logic signed [CompW-1:0] scale_to_unit(
      input logic signed [CompW-1:0] raw, input longint unsigned s);
    longint unsigned mag, rhs, t;
    int unsigned lo, hi, mid;
    mag = (raw < 0) ? longint'(-int'(raw)) : longint'(raw);
    rhs = (mag * mag) << 30;
    lo = 0;
    hi = UnitQ14;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * longint'(mid) - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (raw < 0) ? -CompW'(lo) : CompW'(lo);
  endfunction

  function automatic unit_word_t normalize_quat(input quat_word_t q, input order_t ord);
    logic signed [CompW-1:0] v[4];  // x, y, z, w
    longint unsigned s;
    longint signed sv;
    unit_word_t r;
    if (ord == ORD_WXYZ) begin
      v[3] = q.a; v[0] = q.b; v[1] = q.c; v[2] = q.d;
    end else begin
      v[0] = q.a; v[1] = q.b; v[2] = q.c; v[3] = q.d;
    end
    s = 0;
    for (int i = 0; i < 4; i++) begin
      sv = v[i];
      s += sv * sv;
    end
    r = '0;
    if (s == 0) r.st = ST_ZERO;
    else if (s < SumMinOk || s > SumMaxOk) r.st = ST_RANGE;
    else begin
      r.x = scale_to_unit(v[0], s);
      r.y = scale_to_unit(v[1], s);
      r.z = scale_to_unit(v[2], s);
      r.w = scale_to_unit(v[3], s);
      r.st = (s <= SumWarnLo || s >= SumWarnHi) ? ST_WARN : ST_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Driver: bursts of random length, random gaps. Payload holds while stalled.
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_comp_a <= '0;
      in_comp_b <= '0;
      in_comp_c <= '0;
      in_comp_d <= '0;
    end else if (!(in_valid && in_stall)) begin
      // previous word (if any) was accepted or nothing was offered
      if (in_valid) begin
        expected_units.insert(expected_units.size(),
                              normalize_quat(pending_quats.pop_front(), cur_order));
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        in_valid  <= 1'b1;
        in_comp_a <= pending_quats[0].a;
        in_comp_b <= pending_quats[0].b;
        in_comp_c <= pending_quats[0].c;
        in_comp_d <= pending_quats[0].d;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(0, 12);
          gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: modes switch every so often, including none.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
      end else stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    unit_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        e = expected_units.pop_front();
        if (out_norm_x !== e.x) report_mismatch("norm_x", out_norm_x, e.x);
        if (out_norm_y !== e.y) report_mismatch("norm_y", out_norm_y, e.y);
        if (out_norm_z !== e.z) report_mismatch("norm_z", out_norm_z, e.z);
        if (out_norm_w !== e.w) report_mismatch("norm_w", out_norm_w, e.w);
        if (out_status !== e.st) report_mismatch("status", out_status, e.st);
      end
    end
  end

  task automatic write_order(input order_t ord);
    cfg_valid <= 1'b1;
    cfg_data  <= ord;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_order = ord;
  endtask

  // wait for the block to drain before touching the order bit
  task automatic drain_block();
    while (pending_quats.size() > 0 || in_valid || expected_units.size() > 0)
      @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  function automatic logic signed [CompW-1:0] rand_comp();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return CompW'($urandom);
      1: return 16'sh8000;
      2: return 16'sh7FFF;
      3: return CompW'($urandom_range(0, 8)) - 16'sd4;
      default: return CompW'(int'($urandom_range(0, 12000)) - 6000);
    endcase
  endfunction

  // Quaternion with components uniform in +-scale/2 of unit (scale 1..4), norm 0..4
  function automatic quat_word_t rand_unitish();
    quat_word_t q;
    int scale;
    scale = $urandom_range(1, 4);
    q.a = CompW'(int'($urandom_range(0, 2 * 4096 * scale)) - 4096 * scale);
    q.b = CompW'(int'($urandom_range(0, 2 * 4096 * scale)) - 4096 * scale);
    q.c = CompW'(int'($urandom_range(0, 2 * 4096 * scale)) - 4096 * scale);
    q.d = CompW'(int'($urandom_range(0, 2 * 4096 * scale)) - 4096 * scale);
    return q;
  endfunction

  task automatic queue_quat(input int a, input int b, input int c, input int d);
    quat_word_t q;
    q.a = CompW'(a); q.b = CompW'(b); q.c = CompW'(c); q.d = CompW'(d);
    pending_quats.insert(pending_quats.size(), q);
  endtask

  task automatic queue_random(input int count);
    quat_word_t q;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) q = rand_unitish();
      else begin
        q.a = rand_comp(); q.b = rand_comp(); q.c = rand_comp(); q.d = rand_comp();
      end
      pending_quats.insert(pending_quats.size(), q);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset order (w first).
    queue_quat(8192, 0, 0, 0);              // unit w
    queue_quat(0, 8192, 0, 0);              // unit x
    queue_quat(0, 0, 0, 0);                 // zero quaternion
    queue_quat(0, 0, 0, 1);                 // smallest nonzero, out of range
    queue_quat(4096, 0, 0, 0);              // norm exactly 0.5, accepted
    queue_quat(4095, 0, 0, 0);              // just under 0.5, rejected
    queue_quat(12288, 0, 0, 0);             // norm exactly 1.5, accepted
    queue_quat(12289, 0, 0, 0);             // just over 1.5, rejected
    queue_quat(6553, 0, 0, 0);              // just under 0.8, warns
    queue_quat(6554, 0, 0, 0);              // just over 0.8, no warning
    queue_quat(9830, 0, 0, 0);              // just under 1.2, no warning
    queue_quat(9831, 0, 0, 0);              // just over 1.2, warns
    queue_quat(-32768, -32768, -32768, -32768);  // most negative, rejected
    queue_quat(32767, 32767, 32767, 32767);      // most positive, rejected
    queue_quat(4096, -4096, 4096, -4096);   // equal magnitudes, norm 1
    queue_quat(-8192, 0, 0, 0);             // negative unit w
    queue_quat(1, 2, -3, 8191);             // tiny components beside a near-unit one
    drain_block();

    // Other order, directed then random.
    write_order(ORD_XYZW);
    queue_quat(0, 0, 0, 8192);
    queue_quat(-5000, 3000, 4000, -2000);
    queue_quat(0, 0, 0, 0);
    queue_random(500);
    drain_block();

    write_order(ORD_WXYZ);
    queue_random(400);
    drain_block();

    write_order(ORD_XYZW);
    queue_random(200);
    drain_block();

    if (mismatch_count == 0 && expected_units.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
